FILE: design/ttps_pkg.sv
// Shared types and constants for the transposition table probe/store block.
// Has no dependencies; the top module and ttps_resolve import it.
package ttps_pkg;

  localparam int INDEX_BITS = 20;
  localparam int ADDR_W     = INDEX_BITS + 1;
  localparam int TABLE_SIZE = 1 << ADDR_W;

  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;
  // Stored as given; a probe of such an entry never hits.
  localparam logic [1:0] BOUND_SPARE = 2'd3;

  localparam logic signed [31:0] MISS_SCORE = -32'sd10000000;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // An entry that is not valid stands for a stored depth of minus one.
  typedef struct packed {
    logic               valid;
    logic [5:0]         depth;
    logic [1:0]         bound;
    logic signed [31:0] score;
    logic [63:0]        key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               operation;
    logic [63:0]        position_key;
    logic [5:0]         search_depth;
    logic               side;
    logic signed [31:0] window_low;
    logic signed [31:0] window_high;
    logic [1:0]         bound_kind;
    logic signed [31:0] score;
  } item_t;

  typedef struct packed {
    logic               write;
    logic               hit;
    logic signed [31:0] score;
  } outcome_t;

endpackage

FILE: design/transposition_table_probe_store.sv
// Transposition table probe/store: one result per item, registered at the end
// of ST_LOOKUP; no new item is taken until ST_LOOKUP ends (table read in
// ST_IDLE, then decision and write-back through the single table RAM). A
// result that is not taken holds the decision cycle until the output register
// frees up. After reset a clearing pass writes all 2^(INDEX_BITS+1) entries,
// one per cycle, while item_ready stays low.
module transposition_table_probe_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               operation,
  input  logic [63:0]        position_key,
  input  logic [5:0]         search_depth,
  input  logic               side,
  input  logic signed [31:0] window_low,
  input  logic signed [31:0] window_high,
  input  logic [1:0]         bound_kind,
  input  logic signed [31:0] score,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               hit,
  output logic signed [31:0] result_score
);
  import ttps_pkg::*;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   clr_addr;
  item_t               item;
  logic [ADDR_W-1:0]   item_addr;
  logic                accept;
  logic                out_free;
  logic                finish;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  entry_t              rd_entry;
  entry_t              new_entry;
  outcome_t            outcome;

  assign accept   = item_valid && item_ready;
  assign out_free = !result_valid || result_ready;
  assign finish   = (state == ST_LOOKUP) && out_free;
  assign rd_entry = entry_t'(ram_rdata);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == {ADDR_W{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = item_addr;
    ram_wdata  = ENTRY_W'(new_entry);
    ram_re     = 1'b0;
    ram_raddr  = {side, position_key[INDEX_BITS-1:0]};
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        ram_re     = item_valid;
      end
      ST_LOOKUP: begin
        ram_we = out_free && outcome.write;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.operation    <= operation;
      item.position_key <= position_key;
      item.search_depth <= search_depth;
      item.side         <= side;
      item.window_low   <= window_low;
      item.window_high  <= window_high;
      item.bound_kind   <= bound_kind;
      item.score        <= score;
      item_addr         <= {side, position_key[INDEX_BITS-1:0]};
    end
    if (finish) begin
      hit          <= outcome.hit;
      result_score <= outcome.score;
    end
  end

  ttps_resolve u_resolve (
    .item      (item),
    .entry     (rd_entry),
    .outcome   (outcome),
    .new_entry (new_entry)
  );

  ttps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: design/ttps_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data when no read is issued. No dependencies.
module ttps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/ttps_resolve.sv
// Decides the outcome of one item against the entry read from the table.
// Depends on ttps_pkg.
module ttps_resolve (
  input  ttps_pkg::item_t    item,
  input  ttps_pkg::entry_t   entry,
  output ttps_pkg::outcome_t outcome,
  output ttps_pkg::entry_t   new_entry
);
  import ttps_pkg::*;

  logic match;

  assign match = entry.valid && (entry.key == item.position_key) &&
                 (entry.depth >= item.search_depth);

  always_comb begin
    outcome.write = 1'b0;
    outcome.hit   = 1'b0;
    outcome.score = '0;
    if (item.operation == OP_PROBE) begin
      outcome.score = MISS_SCORE;
      if (match) begin
        case (entry.bound)
          BOUND_EXACT: begin
            outcome.hit   = 1'b1;
            outcome.score = entry.score;
          end
          BOUND_UPPER: begin
            if (entry.score <= item.window_low) begin
              outcome.hit   = 1'b1;
              outcome.score = item.window_low;
            end
          end
          BOUND_LOWER: begin
            if (entry.score >= item.window_high) begin
              outcome.hit   = 1'b1;
              outcome.score = item.window_high;
            end
          end
          default: begin
            outcome.hit = 1'b0;
          end
        endcase
      end
    end else begin
      // A deeper stored entry is kept; anything else is replaced.
      outcome.write = !(entry.valid && (entry.depth > item.search_depth));
      outcome.hit   = outcome.write;
    end
  end

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.depth = item.search_depth;
    new_entry.bound = item.bound_kind;
    new_entry.score = item.score;
    new_entry.key   = item.position_key;
  end

endmodule
